// ===== rtl/core/ritp_pkg.sv =====
// Shared types and constants of the radix integer text parser.
package ritp_pkg;

   // Width of the internal character counter; the reported index is its low 16 bits.
   localparam int INDEX_BITS = 16;

   localparam logic [5:0] RADIX_MAX   = 6'd36;
   localparam logic [5:0] RADIX_RESET = 6'd10;
   localparam logic [5:0] RADIX_ONE   = 6'd1;
   localparam logic [5:0] RADIX_AUTO  = 6'd0;
   localparam logic [5:0] BASE_BIN    = 6'd2;
   localparam logic [5:0] BASE_OCT    = 6'd8;
   localparam logic [5:0] BASE_DEC    = 6'd10;
   localparam logic [5:0] BASE_HEX    = 6'd16;
   localparam logic [5:0] NOT_DIGIT   = 6'd63;

   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NINE     = 8'h39;
   localparam logic [7:0] CH_LC_A     = 8'h61;
   localparam logic [7:0] CH_LC_Z     = 8'h7A;
   localparam logic [7:0] CH_UC_A     = 8'h41;
   localparam logic [7:0] CH_UC_Z     = 8'h5A;
   localparam logic [7:0] CH_LC_A_OFS = 8'h57; // 'a' - 10
   localparam logic [7:0] CH_UC_A_OFS = 8'h37; // 'A' - 10
   localparam logic [7:0] CH_MINUS    = 8'h2D;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_LC_X     = 8'h78;
   localparam logic [7:0] CH_UC_X     = 8'h58;
   localparam logic [7:0] CH_LC_B     = 8'h62;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_MINUS_REJ = 2'd1;
   localparam logic [1:0] STATUS_BAD_RADIX = 2'd2;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RADIX       = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SIGNED_MODE = 2'd1;

   typedef enum logic [2:0] {
      PH_DONE,
      PH_LEAD,
      PH_AFTER_SIGN,
      PH_ZERO,
      PH_DIGITS
   } phase_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       start_req;
   } req_type;

   typedef struct packed {
      logic [63:0] value;
      logic [15:0] end_index;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic [5:0] radix;
      logic       signed_mode;
   } cfg_type;

endpackage

// ===== rtl/core/ritp_csr.sv =====
// Configuration registers of the radix integer text parser.
module ritp_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [ritp_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [ritp_pkg::CSR_DATA_BITS-1:0]     csr_wdata,
   output ritp_pkg::cfg_type                      cfg
);

   logic [5:0] radix_ff, radix_in;
   logic       signed_mode_ff, signed_mode_in;

   assign csr_ready = 1'b1;

   always_comb begin
      radix_in       = radix_ff;
      signed_mode_in = signed_mode_ff;
      if (csr_valid) begin
         case (csr_index)
            ritp_pkg::CSR_RADIX:       radix_in       = csr_wdata[5:0];
            ritp_pkg::CSR_SIGNED_MODE: signed_mode_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff       <= ritp_pkg::RADIX_RESET;
         signed_mode_ff <= 1'b1;
      end else begin
         radix_ff       <= radix_in;
         signed_mode_ff <= signed_mode_in;
      end
   end

   assign cfg.radix       = radix_ff;
   assign cfg.signed_mode = signed_mode_ff;

endmodule

// ===== rtl/core/ritp_in_reg.sv =====
// Input request register of the radix integer text parser.
module ritp_in_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ritp_pkg::req_type req_data,
   input  logic              consume,
   output logic              held_valid,
   output ritp_pkg::req_type held_data
);

   logic              valid_ff, valid_in;
   ritp_pkg::req_type data_ff;

   assign req_ready = !valid_ff || consume;

   always_comb begin
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (consume) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff <= req_data;
      end
   end

   assign held_valid = valid_ff;
   assign held_data  = data_ff;

endmodule

// ===== rtl/core/ritp_step.sv =====
// Parse state and per-character step logic of the radix integer text parser.
module ritp_step (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  ritp_pkg::req_type in_data,
   input  ritp_pkg::cfg_type cfg,
   output logic              emit,
   output ritp_pkg::rsp_type rsp
);

   typedef enum logic [1:0] {
      EM_NONE,
      EM_VALUE,
      EM_MINUS,
      EM_RADIX
   } emit_type;

   ritp_pkg::phase_type               phase_ff, phase_in;
   logic [63:0]                       acc_ff, acc_in;
   logic [5:0]                        base_ff, base_in;
   logic                              neg_ff, neg_in;
   logic [ritp_pkg::INDEX_BITS-1:0]   idx_ff, idx_in;
   emit_type                          kind;

   function automatic logic [5:0] digit_of(input logic [7:0] c);
      logic [7:0] d;
      d = 8'(ritp_pkg::NOT_DIGIT);
      if (c >= ritp_pkg::CH_ZERO && c <= ritp_pkg::CH_NINE) begin
         d = c - ritp_pkg::CH_ZERO;
      end else if (c >= ritp_pkg::CH_LC_A && c <= ritp_pkg::CH_LC_Z) begin
         d = c - ritp_pkg::CH_LC_A_OFS;
      end else if (c >= ritp_pkg::CH_UC_A && c <= ritp_pkg::CH_UC_Z) begin
         d = c - ritp_pkg::CH_UC_A_OFS;
      end
      return d[5:0];
   endfunction

   // Next state: start handling, phase decode, then at most one digit step.
   always_comb begin
      logic [7:0] c;
      logic [5:0] d;
      logic       take_first;
      logic       take_digit;
      logic       advance;

      c          = in_data.ch;
      d          = digit_of(c);
      take_first = 1'b0;
      take_digit = 1'b0;
      advance    = 1'b1;
      kind       = EM_NONE;
      phase_in   = phase_ff;
      acc_in     = acc_ff;
      base_in    = base_ff;
      neg_in     = neg_ff;
      idx_in     = idx_ff;

      if (in_data.start_req) begin
         acc_in  = '0;
         neg_in  = 1'b0;
         idx_in  = '0;
         base_in = cfg.radix;
         if (cfg.radix == ritp_pkg::RADIX_ONE || cfg.radix > ritp_pkg::RADIX_MAX) begin
            kind     = EM_RADIX;
            advance  = 1'b0;
            phase_in = ritp_pkg::PH_DONE;
         end else begin
            phase_in = ritp_pkg::PH_LEAD;
         end
      end

      if (kind == EM_NONE) begin
         case (phase_in)
            ritp_pkg::PH_LEAD: begin
               if (c == ritp_pkg::CH_SPACE ||
                   c inside {[ritp_pkg::CH_TAB:ritp_pkg::CH_CR]}) begin
                  // Leading whitespace is skipped.
               end else if (c == ritp_pkg::CH_MINUS) begin
                  if (!cfg.signed_mode) begin
                     kind     = EM_MINUS;
                     advance  = 1'b0;
                     phase_in = ritp_pkg::PH_DONE;
                  end else begin
                     neg_in   = 1'b1;
                     phase_in = ritp_pkg::PH_AFTER_SIGN;
                  end
               end else begin
                  take_first = 1'b1;
               end
            end
            ritp_pkg::PH_AFTER_SIGN: begin
               take_first = 1'b1;
            end
            ritp_pkg::PH_ZERO: begin
               if (c == ritp_pkg::CH_LC_X || c == ritp_pkg::CH_UC_X) begin
                  base_in  = ritp_pkg::BASE_HEX;
                  phase_in = ritp_pkg::PH_DIGITS;
               end else if (c == ritp_pkg::CH_LC_B) begin
                  base_in  = ritp_pkg::BASE_BIN;
                  phase_in = ritp_pkg::PH_DIGITS;
               end else begin
                  take_digit = 1'b1;
               end
            end
            ritp_pkg::PH_DIGITS: begin
               take_digit = 1'b1;
            end
            default: begin
               // No string active: the character is dropped.
               advance = 1'b0;
            end
         endcase
      end

      if (take_first) begin
         if (base_in == ritp_pkg::RADIX_AUTO) begin
            if (c == ritp_pkg::CH_ZERO) begin
               base_in  = ritp_pkg::BASE_OCT;
               phase_in = ritp_pkg::PH_ZERO;
            end else begin
               base_in    = ritp_pkg::BASE_DEC;
               take_digit = 1'b1;
            end
         end else begin
            take_digit = 1'b1;
         end
      end

      if (take_digit) begin
         if (d < base_in) begin
            acc_in   = 64'(acc_in * {58'd0, base_in}) + {58'd0, d};
            phase_in = ritp_pkg::PH_DIGITS;
         end else begin
            kind     = EM_VALUE;
            advance  = 1'b0;
            phase_in = ritp_pkg::PH_DONE;
         end
      end

      if (advance && idx_in != '1) begin
         idx_in = idx_in + 1'b1;
      end
   end

   // Outputs: the result that this character produces, if any.
   always_comb begin
      emit          = (kind != EM_NONE);
      rsp.value     = '0;
      rsp.end_index = '0;
      rsp.status    = ritp_pkg::STATUS_OK;
      case (kind)
         EM_VALUE: begin
            rsp.value     = neg_in ? (~acc_in + 64'd1) : acc_in;
            rsp.end_index = 16'(idx_in);
         end
         EM_MINUS: rsp.status = ritp_pkg::STATUS_MINUS_REJ;
         EM_RADIX: rsp.status = ritp_pkg::STATUS_BAD_RADIX;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ritp_pkg::PH_DONE;
         acc_ff   <= '0;
         base_ff  <= '0;
         neg_ff   <= 1'b0;
         idx_ff   <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         base_ff  <= base_in;
         neg_ff   <= neg_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

// ===== rtl/core/ritp_out_reg.sv =====
// Result register of the radix integer text parser.
module ritp_out_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  ritp_pkg::rsp_type load_data,
   output logic              has_room,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ritp_pkg::rsp_type rsp_data
);

   logic              valid_ff, valid_in;
   ritp_pkg::rsp_type data_ff;

   assign has_room = !valid_ff || rsp_ready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ===== rtl/core/radix_integer_text_parse_top.sv =====
// Top level of the radix integer text parser: one character per request.
// The request is held in the input register, and its result in the result register on rsp_.
// Throughput: one request per cycle, unless a result waits for a full result register.
// A request that produces no result needs no room in the result register.
// Reset (synchronous, active high) empties both registers, parks the parser idle,
// and sets radix to 10 and signed mode on.
module radix_integer_text_parse_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  ritp_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output ritp_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ritp_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ritp_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   ritp_pkg::cfg_type cfg;
   ritp_pkg::req_type held_data;
   ritp_pkg::rsp_type step_rsp;
   logic              held_valid;
   logic              emit;
   logic              has_room;
   logic              fire;

   // The held request is processed when it yields no result, or when the
   // result register is empty or being drained in this same cycle.
   assign fire = held_valid && (!emit || has_room);

   ritp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ritp_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .consume    (fire),
      .held_valid (held_valid),
      .held_data  (held_data)
   );

   ritp_step u_step (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .in_data (held_data),
      .cfg     (cfg),
      .emit    (emit),
      .rsp     (step_rsp)
   );

   ritp_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (fire && emit),
      .load_data (step_rsp),
      .has_room  (has_room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
